@@ hdl/rbch_pkg.sv @@
// Shared types and constants for the ray versus box closest-hit block.
`default_nettype none

package rbch_pkg;

  // Fixed-point widths of the slab arithmetic.
  localparam int NUM_W = 48;   // magnitude of a scaled slab numerator
  localparam int DEN_W = 16;   // magnitude of a direction component
  localparam int T_W   = 50;   // signed slab distance, with room for the sentinels
  localparam int CNT_W = 6;    // divider step counter, holds NUM_W

  localparam logic [30:0] DIST_MAX = 31'h7FFF_FFFF;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X    = 3'd3;
  localparam logic [2:0] CFG_DIR_Y    = 3'd4;
  localparam logic [2:0] CFG_DIR_Z    = 3'd5;
  localparam logic [2:0] CFG_RAY_LEN  = 3'd6;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AXIS,
    S_DIVA,
    S_DIVB,
    S_SQM,
    S_SQA,
    S_FINAL
  } seq_state_t;

endpackage

`default_nettype wire

@@ hdl/rbch_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle, signed result.
`default_nettype none

module rbch_div (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire rbch_pkg::div_req_t    req,
  output logic                       done,
  output logic signed [rbch_pkg::T_W-1:0] quo
);
  import rbch_pkg::*;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;

    if (busy_r) begin
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_nxt = {quo_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(NUM_W);
      rem_nxt  = '0;
      quo_nxt  = req.num;
      den_nxt  = req.den;
      neg_nxt  = req.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});

endmodule

`default_nettype wire

@@ hdl/ray_box_closest_hit.sv @@
// Top level of the ray versus box stream tester with closest-centre selection.
`default_nettype none

// A ray (origin, direction, length) is written through the cfg_ port; the
// user must do so only while the block is idle, as the block itself does not
// enforce this. Boxes then stream in on the in_ port, one request per box,
// and each box gives one result request on the out_ port. Each enabled box
// is tested by the slab method: for every axis with a nonzero direction
// component two slab distances are formed, each by one pass through a shared
// 48-step radix-2 divider; the squared centre distance is then built up axis
// by axis (a multiply, then an accumulate), and a final step decides the
// box. A new box is accepted only once the previous one has reached its
// decision. Parallel axes skip their divisions, a miss found on a parallel
// axis ends the box early, and a disabled box goes straight to the decision.
// The result sits in an output register, so the next box is accepted while
// it waits.
// The result of the box flagged with tlast carries the summary of the list
// (nearest-centre hit box, its index and distance), after which the running
// summary and the box counter return to their reset values.
module ray_box_closest_hit #(
  parameter int MAX_BOXES = 1024
) (
  input  wire          clk,
  input  wire          rst_n,

  // Configuration write channel.
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [2:0]   cfg_addr,
  input  wire  [31:0]  cfg_data,

  // Box requests.
  input  wire          in_tvalid,
  output logic         in_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64], size_x[126:96],
  // size_y[157:127], size_z[188:158], zero pad[191:189]
  input  wire  [191:0] in_tdata,
  // box_enabled[0]
  input  wire  [0:0]   in_tuser,
  input  wire          in_tlast,   // list_end

  // Result requests.
  output logic         out_tvalid,
  input  wire          out_tready,
  // hit_distance[30:0], closest_index[40:31], closest_distance[71:41]
  output logic [71:0]  out_tdata,
  // hit[0], closest_found[1]
  output logic [1:0]   out_tuser,
  output logic         out_tlast   // result_last
);
  import rbch_pkg::*;

  localparam int CW    = $clog2(MAX_BOXES);
  localparam int IDX_W = 10;

  localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};
  localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};

  // Configuration registers.
  logic signed [31:0] origin_r [3];
  logic signed [15:0] dir_r    [3];
  logic [30:0]        ray_len_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r[0] <= '0;
      origin_r[1] <= '0;
      origin_r[2] <= '0;
      dir_r[0]    <= 16'sd16384;
      dir_r[1]    <= '0;
      dir_r[2]    <= '0;
      ray_len_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_addr)
        CFG_ORIGIN_X: origin_r[0] <= cfg_data;
        CFG_ORIGIN_Y: origin_r[1] <= cfg_data;
        CFG_ORIGIN_Z: origin_r[2] <= cfg_data;
        CFG_DIR_X:    dir_r[0]    <= cfg_data[15:0];
        CFG_DIR_Y:    dir_r[1]    <= cfg_data[15:0];
        CFG_DIR_Z:    dir_r[2]    <= cfg_data[15:0];
        CFG_RAY_LEN:  ray_len_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and the box being worked on.
  seq_state_t state_r, state_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic       ok_r, ok_nxt;
  logic       en_r, en_nxt;
  logic       last_r, last_nxt;

  logic signed [31:0] c_r [3];
  logic [30:0]        s_r [3];
  logic signed [31:0] c_nxt [3];
  logic [30:0]        s_nxt [3];

  logic signed [T_W-1:0] tmin_r, tmin_nxt;
  logic signed [T_W-1:0] tmax_r, tmax_nxt;
  logic signed [T_W-1:0] ta_r, ta_nxt;
  logic [63:0]           prod_r, prod_nxt;
  logic [63:0]           acc_r, acc_nxt;

  // Running list summary.
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          best_found_r, best_found_nxt;
  logic [CW-1:0] best_idx_r, best_idx_nxt;
  logic [63:0]   best_sq_r, best_sq_nxt;
  logic [30:0]   best_dist_r, best_dist_nxt;

  // Output register.
  logic          ov_r, ov_nxt;
  logic [71:0]   od_r, od_nxt;
  logic [1:0]    ou_r, ou_nxt;
  logic          ol_r, ol_nxt;

  // Shared divider.
  div_req_t              div_req;
  logic                  div_done;
  logic signed [T_W-1:0] div_quo;

  rbch_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Per-axis operand selection and slab arithmetic in doubled Q16.16.
  logic signed [31:0] c_sel, o_sel;
  logic [30:0]        s_sel;
  logic signed [15:0] d_sel;
  logic signed [33:0] lo2, hi2;
  logic signed [34:0] o2, lo2x, hi2x, diff_lo, diff_hi;
  logic               par_ok;
  logic [34:0]        mag_lo, mag_hi;
  logic [15:0]        d_mag;
  logic signed [32:0] cd;
  logic [32:0]        cd_mag;
  logic [64:0]        sum65;

  always_comb begin
    c_sel   = c_r[axis_r];
    s_sel   = s_r[axis_r];
    o_sel   = origin_r[axis_r];
    d_sel   = dir_r[axis_r];
    lo2     = {c_sel[31], c_sel, 1'b0} - {3'b000, s_sel};
    hi2     = {c_sel[31], c_sel, 1'b0} + {3'b000, s_sel};
    o2      = {{2{o_sel[31]}}, o_sel, 1'b0};
    lo2x    = {lo2[33], lo2};
    hi2x    = {hi2[33], hi2};
    diff_lo = lo2x - o2;
    diff_hi = hi2x - o2;
    par_ok  = (o2 >= lo2x) && (o2 <= hi2x);
    mag_lo  = diff_lo[34] ? 35'(-diff_lo) : 35'(diff_lo);
    mag_hi  = diff_hi[34] ? 35'(-diff_hi) : 35'(diff_hi);
    d_mag   = d_sel[15] ? 16'(-d_sel) : 16'(d_sel);
    cd      = {c_sel[31], c_sel} - {o_sel[31], o_sel};
    cd_mag  = cd[32] ? 33'(-cd) : 33'(cd);
    sum65   = {1'b0, acc_r} + {1'b0, prod_r};
  end

  // Final decision for the box.
  logic signed [T_W-1:0] t_sel;
  logic [30:0]           t_sat;
  logic                  box_hit;
  logic                  take_best;
  logic [CW+IDX_W-1:0]   idx_ext;

  always_comb begin
    t_sel   = tmin_r[T_W-1] ? tmax_r : tmin_r;
    t_sat   = (|t_sel[T_W-2:31]) ? DIST_MAX : t_sel[30:0];
    box_hit = en_r && ok_r && !tmax_r[T_W-1] && (tmin_r <= tmax_r) && (t_sat < ray_len_r);
    take_best = box_hit && (!best_found_r || (acc_r < best_sq_r));
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    axis_nxt       = axis_r;
    ok_nxt         = ok_r;
    en_nxt         = en_r;
    last_nxt       = last_r;
    c_nxt          = c_r;
    s_nxt          = s_r;
    tmin_nxt       = tmin_r;
    tmax_nxt       = tmax_r;
    ta_nxt         = ta_r;
    prod_nxt       = prod_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_sq_nxt    = best_sq_r;
    best_dist_nxt  = best_dist_r;
    ov_nxt         = ov_r && !out_tready;
    od_nxt         = od_r;
    ou_nxt         = ou_r;
    ol_nxt         = ol_r;
    idx_ext        = '0;

    div_req.start = 1'b0;
    div_req.neg   = diff_lo[34] ^ d_sel[15];
    div_req.num   = {mag_lo[33:0], 13'b0, 1'b0} >> 1;
    div_req.den   = d_mag;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          c_nxt[0] = in_tdata[31:0];
          c_nxt[1] = in_tdata[63:32];
          c_nxt[2] = in_tdata[95:64];
          s_nxt[0] = in_tdata[126:96];
          s_nxt[1] = in_tdata[157:127];
          s_nxt[2] = in_tdata[188:158];
          en_nxt   = in_tuser[0];
          last_nxt = in_tlast;
          axis_nxt = 2'd0;
          ok_nxt   = 1'b1;
          tmin_nxt = T_MIN;
          tmax_nxt = T_MAX;
          acc_nxt  = '0;
          state_nxt = in_tuser[0] ? S_AXIS : S_FINAL;
        end
      end
      S_AXIS: begin
        if (d_sel == 16'sd0) begin
          if (!par_ok) begin
            ok_nxt    = 1'b0;
            state_nxt = S_FINAL;
          end else if (axis_r == 2'd2) begin
            axis_nxt  = 2'd0;
            state_nxt = S_SQM;
          end else begin
            axis_nxt  = axis_r + 2'd1;
          end
        end else begin
          div_req.start = 1'b1;
          state_nxt     = S_DIVA;
        end
      end
      S_DIVA: begin
        if (div_done) begin
          ta_nxt        = div_quo;
          div_req.start = 1'b1;
          div_req.neg   = diff_hi[34] ^ d_sel[15];
          div_req.num   = {mag_hi[33:0], 13'b0, 1'b0} >> 1;
          state_nxt     = S_DIVB;
        end
      end
      S_DIVB: begin
        if (div_done) begin
          if (((ta_r < div_quo) ? ta_r : div_quo) > tmin_r) begin
            tmin_nxt = (ta_r < div_quo) ? ta_r : div_quo;
          end
          if (((ta_r < div_quo) ? div_quo : ta_r) < tmax_r) begin
            tmax_nxt = (ta_r < div_quo) ? div_quo : ta_r;
          end
          if (axis_r == 2'd2) begin
            axis_nxt  = 2'd0;
            state_nxt = S_SQM;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_AXIS;
          end
        end
      end
      S_SQM: begin
        prod_nxt  = cd_mag[31:0] * cd_mag[31:0];
        state_nxt = S_SQA;
      end
      S_SQA: begin
        acc_nxt = sum65[64] ? '1 : sum65[63:0];
        if (axis_r == 2'd2) begin
          state_nxt = S_FINAL;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_SQM;
        end
      end
      S_FINAL: begin
        if (!ov_r || out_tready) begin
          if (take_best) begin
            best_found_nxt = 1'b1;
            best_idx_nxt   = cnt_r;
            best_sq_nxt    = acc_r;
            best_dist_nxt  = t_sat;
          end
          idx_ext = {{IDX_W{1'b0}}, best_idx_nxt};
          ov_nxt  = 1'b1;
          od_nxt  = {best_found_nxt ? best_dist_nxt : 31'd0,
                     best_found_nxt ? idx_ext[IDX_W-1:0] : 10'd0,
                     box_hit ? t_sat : 31'd0};
          ou_nxt  = {best_found_nxt, box_hit};
          ol_nxt  = last_r;
          if (last_r) begin
            cnt_nxt        = '0;
            best_found_nxt = 1'b0;
            best_idx_nxt   = '0;
            best_sq_nxt    = '1;
            best_dist_nxt  = '0;
          end else begin
            cnt_nxt = (cnt_r == CW'(MAX_BOXES - 1)) ? '0 : cnt_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      axis_r       <= '0;
      cnt_r        <= '0;
      best_found_r <= 1'b0;
      best_idx_r   <= '0;
      best_sq_r    <= '1;
      best_dist_r  <= '0;
      ov_r         <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      axis_r       <= axis_nxt;
      cnt_r        <= cnt_nxt;
      best_found_r <= best_found_nxt;
      best_idx_r   <= best_idx_nxt;
      best_sq_r    <= best_sq_nxt;
      best_dist_r  <= best_dist_nxt;
      ov_r         <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r   <= ok_nxt;
    en_r   <= en_nxt;
    last_r <= last_nxt;
    c_r    <= c_nxt;
    s_r    <= s_nxt;
    tmin_r <= tmin_nxt;
    tmax_r <= tmax_nxt;
    ta_r   <= ta_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

`ifndef ASSERT_OFF
  // A box request keeps the sequencer busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("box accepted while the previous one was still in work");

  // A box that is hit always leaves a valid summary.
  a_hit_implies_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[1])
    else $error("hit reported without a closest box");

  // Without a closest box the summary fields read zero.
  a_empty_summary: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[71:31] == 41'd0)
    else $error("summary fields set with no closest box");

  // A missed box reports a zero distance.
  a_miss_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[30:0] == 31'd0)
    else $error("distance reported on a missed box");
`endif

endmodule

`default_nettype wire
